// File: rtl/cclab_pkg.sv
package cclab_pkg;

  localparam int MAX_V  = 32;
  localparam int VIDX_W = $clog2(MAX_V);
  localparam int VCNT_W = VIDX_W + 1;
  localparam int ROW_W  = 32;

  localparam logic [VCNT_W-1:0] MAX_V_CNT = VCNT_W'(MAX_V);

  // Register map (word index)
  localparam logic REG_VERTEX_COUNT = 1'b0;

  // One transaction handed from the front to the back
  typedef struct packed {
    logic              run;        // graph complete: label and report
    logic [VCNT_W-1:0] row_idx;    // store slot for this row
    logic [ROW_W-1:0]  row;
    logic [VCNT_W-1:0] n;          // effective vertex count
    logic [VCNT_W-1:0] rows_seen;  // rows valid for this graph
  } cmd_t;

  typedef struct packed {
    logic              valid;
    logic [VIDX_W-1:0] index;
    logic [5:0]        label;
    logic              last;
  } res_t;

endpackage

// File: rtl/cclab_front.sv
module cclab_front
  import cclab_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [ROW_W-1:0]  row_bits,
  input  logic              row_last,
  input  logic [5:0]        vertex_count,
  input  logic              fifo_full,
  input  logic              done,
  output logic              busy,
  output logic              push,
  output cmd_t              push_cmd
);

  logic [VCNT_W-1:0] row_counter;
  logic [VCNT_W-1:0] row_counter_next;
  logic              run_pending;
  logic [VCNT_W-1:0] n_eff;
  logic [VCNT_W-1:0] cnt_inc;
  logic              run;

  always_comb begin
    if (vertex_count == '0) begin
      n_eff = VCNT_W'(1);
    end else if (vertex_count > MAX_V_CNT) begin
      n_eff = MAX_V_CNT;
    end else begin
      n_eff = vertex_count;
    end
  end

  assign busy    = run_pending | fifo_full;
  assign push    = start & ~busy;
  assign cnt_inc = row_counter + VCNT_W'(1);
  assign run     = row_last | (cnt_inc >= n_eff);

  always_comb begin
    push_cmd.run       = run;
    push_cmd.row_idx   = row_counter;
    push_cmd.row       = row_bits;
    push_cmd.n         = n_eff;
    push_cmd.rows_seen = (cnt_inc > n_eff) ? n_eff : cnt_inc;
    row_counter_next   = run ? '0 : cnt_inc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_counter <= '0;
      run_pending <= 1'b0;
    end else begin
      if (push) begin
        row_counter <= row_counter_next;
      end
      // only one graph in labelling at a time
      if (push && run) begin
        run_pending <= 1'b1;
      end else if (done) begin
        run_pending <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/cclab_cmd_fifo.sv
module cclab_cmd_fifo
  import cclab_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic empty,
  output logic full
);

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign empty   = (count == 2'd0);
  assign full    = (count == 2'd2);
  assign pop_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/cclab_back.sv
module cclab_back
  import cclab_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cmd_avail,
  input  cmd_t cmd,
  output logic pop,
  output logic done,
  output res_t res
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SEED   = 5'b00010,
    ST_PICK   = 5'b00100,
    ST_EXPAND = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_t;

  state_t            state;
  logic [ROW_W-1:0]  adj_mem [MAX_V];
  logic [ROW_W-1:0]  rd_q;
  logic [5:0]        labels [MAX_V];
  logic [MAX_V-1:0]  visited;
  logic [MAX_V-1:0]  frontier;
  logic [VCNT_W-1:0] n_q;
  logic [VCNT_W-1:0] seen_q;
  logic [VCNT_W-1:0] s_q;
  logic              v_ok;
  logic [5:0]        comp;
  logic [VIDX_W-1:0] e_q;

  logic              mem_we;
  logic [MAX_V-1:0]  low_bit;
  logic [VIDX_W-1:0] pick_idx;
  logic [MAX_V-1:0]  nmask;
  logic [MAX_V-1:0]  new_bits;
  logic              emit_last;

  assign pop    = (state == ST_IDLE) && cmd_avail;
  assign mem_we = pop && !cmd.row_idx[VCNT_W-1];

  // lowest pending vertex of the frontier
  assign low_bit = frontier & (~frontier + MAX_V'(1));
  always_comb begin
    pick_idx = '0;
    for (int i = 0; i < MAX_V; i++) begin
      if (low_bit[i]) begin
        pick_idx = pick_idx | VIDX_W'(i);
      end
    end
  end

  always_comb begin
    for (int j = 0; j < MAX_V; j++) begin
      nmask[j] = (VCNT_W'(j) < n_q);
    end
  end

  // rows not received for this graph carry no edges
  assign new_bits  = (v_ok ? (rd_q & nmask) : '0) & ~visited;
  assign emit_last = ({1'b0, e_q} + VCNT_W'(1)) == n_q;
  assign done      = (state == ST_EMIT) && emit_last;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      adj_mem[cmd.row_idx[VIDX_W-1:0]] <= cmd.row;
    end
    rd_q <= adj_mem[pick_idx];
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_V; i++) begin
      if (state == ST_SEED && s_q != n_q && !visited[s_q[VIDX_W-1:0]]
          && s_q[VIDX_W-1:0] == VIDX_W'(i)) begin
        labels[i] <= comp + 6'd1;
      end else if (state == ST_EXPAND && new_bits[i]) begin
        labels[i] <= comp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res.valid <= 1'b0;
    end else begin
      res.valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (pop && cmd.run) begin
            n_q     <= cmd.n;
            seen_q  <= cmd.rows_seen;
            visited <= '0;
            comp    <= '0;
            s_q     <= '0;
            state   <= ST_SEED;
          end
        end
        ST_SEED: begin
          if (s_q == n_q) begin
            e_q   <= '0;
            state <= ST_EMIT;
          end else if (visited[s_q[VIDX_W-1:0]]) begin
            s_q <= s_q + VCNT_W'(1);
          end else begin
            comp     <= comp + 6'd1;
            visited  <= visited | (MAX_V'(1) << s_q[VIDX_W-1:0]);
            frontier <= MAX_V'(1) << s_q[VIDX_W-1:0];
            state    <= ST_PICK;
          end
        end
        ST_PICK: begin
          if (frontier == '0) begin
            s_q   <= s_q + VCNT_W'(1);
            state <= ST_SEED;
          end else begin
            frontier <= frontier & ~low_bit;
            v_ok     <= {1'b0, pick_idx} < seen_q;
            state    <= ST_EXPAND;
          end
        end
        ST_EXPAND: begin
          visited  <= visited | new_bits;
          frontier <= frontier | new_bits;
          state    <= ST_PICK;
        end
        ST_EMIT: begin
          res.valid <= 1'b1;
          res.index <= e_q;
          res.label <= labels[e_q];
          res.last  <= emit_last;
          e_q       <= e_q + VIDX_W'(1);
          if (emit_last) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/bfs_connected_component_labeler_top.sv
// Connected-component labeller over an adjacency matrix. Rows arrive one per
// transaction (start high while busy is low), one per cycle while loading;
// a row with row_last set, or the row that reaches vertex_count, closes the
// graph. Busy then stays high while the back end searches breadth-first and
// reports one result per vertex, in index order, on consecutive cycles with
// result_valid high; the receiver cannot stall, so results must be taken as
// they appear. After the closing row the search tries each vertex in turn as a
// seed, expands each reached vertex (one adjacency memory read, then one
// parallel neighbour update of the whole row), drains each component's
// frontier and then emits one result per vertex.
// vertex_count (word 0, reset 32) is saturated to 1..32 and should be written
// only while the block is idle.
module bfs_connected_component_labeler_top
  import cclab_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // APB configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // row input
  input  logic              start,
  output logic              busy,
  input  logic [ROW_W-1:0]  row_bits,
  input  logic              row_last,
  // results
  output logic              result_valid,
  output logic [VIDX_W-1:0] vertex_index,
  output logic [5:0]        component_label,
  output logic              result_last
);

  logic [5:0] vertex_count;
  logic       cfg_wr;
  logic       push;
  cmd_t       push_cmd;
  logic       pop;
  cmd_t       pop_cmd;
  logic       fifo_empty;
  logic       fifo_full;
  logic       done;
  res_t       res;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= 6'd32;
    end else if (cfg_wr && paddr[2] == REG_VERTEX_COUNT) begin
      vertex_count <= pwdata[5:0];
    end
  end

  assign prdata = (paddr[2] == REG_VERTEX_COUNT) ? {26'b0, vertex_count} : 32'b0;

  // front: counts rows, decides when the graph is complete
  cclab_front u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .row_bits     (row_bits),
    .row_last     (row_last),
    .vertex_count (vertex_count),
    .fifo_full    (fifo_full),
    .done         (done),
    .busy         (busy),
    .push         (push),
    .push_cmd     (push_cmd)
  );

  // short command queue between front and back
  cclab_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (fifo_empty),
    .full     (fifo_full)
  );

  // back: row store, BFS labelling and result stream
  cclab_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_avail (~fifo_empty),
    .cmd       (pop_cmd),
    .pop       (pop),
    .done      (done),
    .res       (res)
  );

  assign result_valid    = res.valid;
  assign vertex_index    = res.index;
  assign component_label = res.label;
  assign result_last     = res.last;

`ifndef SYNTHESIS
  // labels start at 1
  a_label_nonzero: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> component_label != 6'd0)
    else $error("zero component label");

  // results of one graph leave back to back, indices counting up
  a_result_run: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_last |=>
      result_valid && vertex_index == $past(vertex_index) + 5'd1)
    else $error("broken result sequence");

  // a row with row_last set locks out further rows
  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && row_last |=> busy)
    else $error("busy not raised after last row");
`endif

endmodule
